@@ rtl/core/cti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_pkg: shared definitions for the calibration table interpolator
// Widths, table constants, status and operation codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned BASE_W          = 10;
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned TENTHS          = 10;

  localparam logic [DATA_W-1:0] EMPTY_ENTRY = '1;

  // operation codes carried in the user field of the input word
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_BLANK  = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BELOW   = 2'd1,
    STATUS_UNBOUND = 2'd2,
    STATUS_REJECT  = 2'd3
  } status_e;

  // which result the output register is loaded with
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_REJECT,
    RES_BELOW,
    RES_UNBOUND,
    RES_EXACT,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic     load_item;   // capture the accepted input word
    logic     mem_wr;      // single entry write from the captured word
    logic     clr_step;    // write one empty entry of the clearing sweep
    logic     walk_start;  // rewind the table walk
    logic     walk_step;   // issue next read and judge the previous entry
    logic     div_start;   // launch the shared divider
    logic     div_frac;    // 0: step division, 1: fraction division
    logic     step_latch;  // keep the divider quotient as the step
    logic     out_load;    // load the output register
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_ok;
    logic       rd_valid;
    logic       ent_empty;
    logic       ent_gt;      // count above entry
    logic       ent_lt;      // count below entry
    logic       ent_eq;
    logic       have_lower;
    logic       rd_last;
    logic       clr_last;
    logic       div_done;
    logic       step_zero;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/core/cti_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; the quotient is held after
// the done pulse until the next start.
// ----------------------------------------------------------------------------
module cti_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cti_pkg::DATA_W-1:0] dividend_i,
  input  logic [cti_pkg::DATA_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [cti_pkg::DATA_W-1:0] quotient_o
);
  import cti_pkg::*;

  localparam int unsigned W  = DATA_W;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial;

  // trial subtraction of the shifted partial remainder
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // done only ever closes a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

@@ rtl/core/cti_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_datapath: table memory, walk registers, divider and output register
// Executes the controller's commands and reports comparisons and progress.
// ----------------------------------------------------------------------------
module cti_datapath #(
  parameter int unsigned TableDepth = cti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cti_pkg::cmd_t              cmd_i,
  output cti_pkg::sts_t              sts_o,
  input  logic [1:0]                 item_op_i,
  input  logic [cti_pkg::IDX_W-1:0]  item_idx_i,
  input  logic [cti_pkg::DATA_W-1:0] item_val_i,
  input  logic [cti_pkg::DATA_W-1:0] item_cnt_i,
  input  logic                       cfg_we_i,
  input  logic [cti_pkg::BASE_W-1:0] cfg_wdata_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [cti_pkg::DATA_W-1:0] out_mag_o,
  output logic [1:0]                 out_status_o
);
  import cti_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned SW = ((AW > BASE_W) ? AW : BASE_W) + 1;
  localparam int unsigned MW = SW + 4;
  localparam int unsigned GW = AW + 4;
  localparam logic [AW-1:0] LastAddr = AW'(TableDepth - 1);

  // captured input word
  logic [1:0]        item_op_q;
  logic [IDX_W-1:0]  item_idx_q;
  logic [DATA_W-1:0] item_val_q, item_cnt_q;

  logic [BASE_W-1:0] base_q;

  // table memory
  logic [DATA_W-1:0] mem_q [TableDepth];
  logic [DATA_W-1:0] rd_q;
  logic [AW-1:0]     rd_addr_q, rd_idx_q, clr_addr_q;
  logic              rd_vld_q;

  // brackets
  logic [DATA_W-1:0] lower_val_q, upper_val_q, step_q;
  logic [AW-1:0]     lower_idx_q, upper_idx_q;
  logic              have_lower_q;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_mag_q;
  status_e           out_status_q;

  logic              idx_ok, wr_en, rd_last, clr_last, ent_empty, eval;
  logic [DATA_W-1:0] idx_ext, wr_data, div_dividend, div_divisor, div_quot;
  logic [AW-1:0]     wr_addr, gap;
  logic [GW-1:0]     gap10;
  logic [SW-1:0]     lo_sum, up_sum;
  logic [MW-1:0]     lo_mag, up_mag;
  logic              div_busy, div_done;
  logic [DATA_W-1:0] res_mag;
  status_e           res_status;

  // input word and configuration register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_op_q  <= item_op_i;
      item_idx_q <= item_idx_i;
      item_val_q <= item_val_i;
      item_cnt_q <= item_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // write port: clearing sweep or single entry write
  assign idx_ext  = DATA_W'(item_idx_q);
  assign idx_ok   = (idx_ext < TableDepth);
  assign clr_last = (clr_addr_q == LastAddr);
  assign wr_en    = (cmd_i.mem_wr && idx_ok) || cmd_i.clr_step;
  assign wr_addr  = cmd_i.clr_step ? clr_addr_q : idx_ext[AW-1:0];
  assign wr_data  = cmd_i.clr_step ? EMPTY_ENTRY : item_val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.walk_step) begin
      rd_q <= mem_q[rd_addr_q];
    end
  end

  // sweep and walk address counters
  assign rd_last = (rd_idx_q == LastAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      rd_addr_q  <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
      end
      if (cmd_i.walk_start) begin
        rd_addr_q <= '0;
        rd_vld_q  <= 1'b0;
      end else if (cmd_i.walk_step) begin
        rd_idx_q  <= rd_addr_q;
        rd_addr_q <= (rd_addr_q == LastAddr) ? '0 : rd_addr_q + AW'(1);
        rd_vld_q  <= 1'b1;
      end
    end
  end

  // judge the entry read in the previous cycle
  assign ent_empty = (rd_q == EMPTY_ENTRY);
  assign eval      = cmd_i.walk_step && rd_vld_q && !ent_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_lower_q <= 1'b0;
    end else if (cmd_i.walk_start) begin
      have_lower_q <= 1'b0;
    end else if (eval && (item_cnt_q > rd_q)) begin
      have_lower_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval && (item_cnt_q > rd_q)) begin
      lower_val_q <= rd_q;
      lower_idx_q <= rd_idx_q;
    end
    if (eval && (item_cnt_q <= rd_q)) begin
      upper_val_q <= rd_q;
      upper_idx_q <= rd_idx_q;
    end
    if (cmd_i.step_latch) begin
      step_q <= div_quot;
    end
  end

  // divider operands: step per tenth, then fraction
  assign gap          = upper_idx_q - lower_idx_q;
  assign gap10        = GW'(gap) * GW'(TENTHS);
  assign div_dividend = cmd_i.div_frac ? (item_cnt_q - lower_val_q)
                                       : (upper_val_q - lower_val_q);
  assign div_divisor  = cmd_i.div_frac ? step_q : DATA_W'(gap10);

  cti_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // magnitudes times 10 of the bracket indices
  assign lo_sum = SW'(lower_idx_q) + SW'(base_q);
  assign up_sum = SW'(upper_idx_q) + SW'(base_q);
  assign lo_mag = MW'(lo_sum) * MW'(TENTHS);
  assign up_mag = MW'(up_sum) * MW'(TENTHS);

  // result selection
  always_comb begin
    res_mag    = '0;
    res_status = STATUS_OK;
    case (cmd_i.res_sel)
      RES_ZERO: begin
        res_mag    = '0;
        res_status = STATUS_OK;
      end
      RES_REJECT: begin
        res_mag    = '0;
        res_status = STATUS_REJECT;
      end
      RES_BELOW: begin
        res_mag    = '1;
        res_status = STATUS_BELOW;
      end
      RES_UNBOUND: begin
        res_mag    = DATA_W'(1);
        res_status = STATUS_UNBOUND;
      end
      RES_EXACT: begin
        res_mag    = DATA_W'(up_mag);
        res_status = STATUS_OK;
      end
      RES_INTERP: begin
        res_mag    = DATA_W'(lo_mag) + ((step_q == '0) ? '0 : div_quot);
        res_status = STATUS_OK;
      end
      default: begin
        res_mag    = '0;
        res_status = STATUS_OK;
      end
    endcase
  end

  // output register, frees as the receiver takes the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mag_q    <= res_mag;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_mag_o    = out_mag_q;
  assign out_status_o = out_status_q;

  // status towards the controller
  always_comb begin
    sts_o            = '0;
    sts_o.op         = item_op_q;
    sts_o.idx_ok     = idx_ok;
    sts_o.rd_valid   = rd_vld_q;
    sts_o.ent_empty  = ent_empty;
    sts_o.ent_gt     = !ent_empty && (item_cnt_q > rd_q);
    sts_o.ent_lt     = !ent_empty && (item_cnt_q < rd_q);
    sts_o.ent_eq     = !ent_empty && (item_cnt_q == rd_q);
    sts_o.have_lower = have_lower_q;
    sts_o.rd_last    = rd_last;
    sts_o.clr_last   = clr_last;
    sts_o.div_done   = div_done;
    sts_o.step_zero  = (step_q == '0);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before it was taken");

  a_interp_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && (cmd_i.res_sel == RES_INTERP))
      |-> (have_lower_q && (upper_idx_q > lower_idx_q)))
    else $error("interpolation without an ordered bracket");

endmodule

@@ rtl/core/cti_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_controller: sequencer for the calibration table interpolator
// Runs the clearing sweep, decodes each word and steps the table walk and
// up to two divisions, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cti_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output cti_pkg::cmd_t cmd_o,
  input  cti_pkg::sts_t sts_i
);
  import cti_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_DIV_STEP,
    ST_WAIT_STEP,
    ST_DIV_FRAC,
    ST_WAIT_FRAC,
    ST_BLANK,
    ST_RESP
  } state_e;

  state_e   state_q;
  res_sel_e res_sel_q;

  // state and registered result selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      res_sel_q <= RES_ZERO;
    end else begin
      case (state_q)
        ST_INIT: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_DECODE;
        end
        ST_DECODE: begin
          case (sts_i.op)
            OP_WRITE: begin
              res_sel_q <= sts_i.idx_ok ? RES_ZERO : RES_REJECT;
              state_q   <= ST_RESP;
            end
            OP_LOOKUP: begin
              state_q <= ST_WALK;
            end
            OP_BLANK: begin
              res_sel_q <= RES_ZERO;
              state_q   <= ST_BLANK;
            end
            default: begin
              res_sel_q <= RES_ZERO;
              state_q   <= ST_RESP;
            end
          endcase
        end
        ST_WALK: begin
          if (sts_i.rd_valid) begin
            if (sts_i.ent_eq) begin
              res_sel_q <= RES_EXACT;
              state_q   <= ST_RESP;
            end else if (sts_i.ent_lt) begin
              if (sts_i.have_lower) begin
                state_q <= ST_DIV_STEP;
              end else begin
                res_sel_q <= RES_BELOW;
                state_q   <= ST_RESP;
              end
            end else if (sts_i.rd_last) begin
              res_sel_q <= RES_UNBOUND;
              state_q   <= ST_RESP;
            end
          end
        end
        ST_DIV_STEP: begin
          state_q <= ST_WAIT_STEP;
        end
        ST_WAIT_STEP: begin
          if (sts_i.div_done) state_q <= ST_DIV_FRAC;
        end
        ST_DIV_FRAC: begin
          res_sel_q <= RES_INTERP;
          state_q   <= sts_i.step_zero ? ST_RESP : ST_WAIT_FRAC;
        end
        ST_WAIT_FRAC: begin
          if (sts_i.div_done) state_q <= ST_RESP;
        end
        ST_BLANK: begin
          if (sts_i.clr_last) state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // commands decoded from the state
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_sel    = res_sel_q;
    cmd_o.load_item  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mem_wr     = (state_q == ST_DECODE) && (sts_i.op == OP_WRITE);
    cmd_o.clr_step   = (state_q == ST_INIT) || (state_q == ST_BLANK);
    cmd_o.walk_start = (state_q == ST_DECODE);
    cmd_o.walk_step  = (state_q == ST_WALK);
    cmd_o.div_start  = (state_q == ST_DIV_STEP) ||
                       ((state_q == ST_DIV_FRAC) && !sts_i.step_zero);
    cmd_o.div_frac   = (state_q == ST_DIV_FRAC);
    cmd_o.step_latch = (state_q == ST_WAIT_STEP) && sts_i.div_done;
    cmd_o.out_load   = (state_q == ST_RESP) && sts_i.out_free;
  end

endmodule

@@ rtl/core/calibration_table_interpolate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibration_table_interpolate: calibration table with linear interpolation
// Each input word carries an operation in tuser: write one table entry, look
// up a period count, or blank the whole table. Every word gives exactly one
// result word: magnitude times 10 in tdata and a status code in tuser.
// The base magnitude register is written through cfg_we_i / cfg_wdata_i;
// write it only while the block is idle (the block does not enforce this).
// A word is taken only when the sequencer is idle. A blank sweeps the
// table one entry a cycle. A lookup walks the table memory one entry a
// cycle through its registered read port, then runs up to two divisions
// on the shared divider.
// After reset a clearing pass marks every entry empty; no word is taken
// during it.
// A finished result sits in the output register; the next word is taken
// while it waits, and its own result is held back until the receiver has
// taken the previous one.
// ----------------------------------------------------------------------------
module calibration_table_interpolate #(
  parameter int unsigned TableDepth = cti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [7:0] entry_index, [39:8] entry_value, [71:40] period_count
  input  logic [71:0]                s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]                 s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [31:0] magnitude_x10 (signed)
  output logic [31:0]                m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                 m_axis_tuser_o,
  input  logic                       cfg_we_i,
  input  logic [cti_pkg::BASE_W-1:0] cfg_wdata_i
);
  import cti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cti_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cti_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_op_i    (s_axis_tuser_i),
    .item_idx_i   (s_axis_tdata_i[7:0]),
    .item_val_i   (s_axis_tdata_i[39:8]),
    .item_cnt_i   (s_axis_tdata_i[71:40]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_mag_o    (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule
